// File: hw/rtl/tpmf_pkg.sv
// Shared widths, register indexes, reset values and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package tpmf_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned REC_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd6;

  // Configuration reset values
  localparam logic [SAMPLE_W-1:0] RST_THRESH = 10'd3;
  localparam logic [SAMPLE_W-1:0] RST_LEFT   = 10'd957;
  localparam logic [SAMPLE_W-1:0] RST_RIGHT  = 10'd54;
  localparam logic [SAMPLE_W-1:0] RST_TOP    = 10'd936;
  localparam logic [SAMPLE_W-1:0] RST_BOTTOM = 10'd92;
  localparam logic [SIZE_W-1:0]   RST_WIDTH  = 16'd18750;
  localparam logic [SIZE_W-1:0]   RST_HEIGHT = 16'd14100;

  // Serial divider: dividend is size * |offset| + |span|, at most 28 bits
  localparam int unsigned DIV_W     = 28;
  localparam int unsigned DIV_STEPS = 28;
  localparam int unsigned DIV_CNT_W = 5;

  // Saturation limits
  localparam logic [POS_W-1:0] POS_MAX = 16'h7fff;
  localparam logic [POS_W-1:0] POS_MIN = 16'h8000;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_window;  // write accepted word into window
    logic eval;         // register vote and medians
    logic setup;        // register span and offset magnitudes for current axis
    logic mul;          // load dividend
    logic div_step;     // one restoring division step
    logic finish;       // apply sign, saturate and store current axis
    logic emit;         // load output register
    logic axis;         // 0: physical X, 1: physical Y
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_slot;
    logic vote_pass;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/tpmf_ctrl.sv
// Sequencer for window collection, vote, two-axis mapping and record output.
`timescale 1ns / 1ps
`default_nettype none

module tpmf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output tpmf_pkg::dp_cmd_t       cmd,
  input  wire tpmf_pkg::dp_stat_t stat
);
  import tpmf_pkg::*;

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_EVAL    = 3'd1;
  localparam logic [2:0] S_SETUP   = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_DIV     = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic                 axis;
  logic                 axis_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;

  // Next state and command decode
  always_comb begin
    state_next   = state;
    axis_next    = axis;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.axis     = axis;
    in_ready     = 1'b0;
    case (state)
      S_COLLECT: begin
        in_ready        = 1'b1;
        cmd.load_window = in_valid;
        if (in_valid && stat.last_slot) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        axis_next  = 1'b0;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        if (stat.vote_pass) begin
          cmd.setup  = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_MUL: begin
        cmd.mul      = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (axis) begin
          state_next = S_EMIT;
        end else begin
          axis_next  = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_COLLECT;
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

  // Hold state, axis and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_COLLECT;
      axis    <= 1'b0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      axis    <= axis_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tpmf_dp.sv
// Datapath: configuration, sample window, vote, medians, mapping divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module tpmf_dp #(
  parameter int unsigned WINDOW = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tpmf_pkg::dp_cmd_t                   cmd,
  output tpmf_pkg::dp_stat_t                       stat,
  input  wire logic [tpmf_pkg::SAMPLE_W-1:0]       sample_x,
  input  wire logic [tpmf_pkg::SAMPLE_W-1:0]       sample_y,
  input  wire logic [tpmf_pkg::SAMPLE_W-1:0]       pressure,
  input  wire logic                                cfg_write,
  input  wire logic [tpmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tpmf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [tpmf_pkg::REC_W-1:0]               record_number,
  output logic signed [tpmf_pkg::POS_W-1:0]        pos_x_centi,
  output logic signed [tpmf_pkg::POS_W-1:0]        pos_y_centi,
  output logic                                     position_valid
);
  import tpmf_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned MID    = WINDOW / 2;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  // Configuration registers
  logic [SAMPLE_W-1:0] thresh;
  logic [SAMPLE_W-1:0] edge_left;
  logic [SAMPLE_W-1:0] edge_right;
  logic [SAMPLE_W-1:0] edge_top;
  logic [SAMPLE_W-1:0] edge_bottom;
  logic [SIZE_W-1:0]   plate_width;
  logic [SIZE_W-1:0]   plate_height;

  // Window
  logic [SAMPLE_W-1:0] x_win [WINDOW];
  logic [SAMPLE_W-1:0] y_win [WINDOW];
  logic [WINDOW-1:0]   marks;
  logic [SLOT_W-1:0]   slot;

  // Vote and medians
  logic [CNT_W-1:0]    rank_x [WINDOW];
  logic [CNT_W-1:0]    rank_y [WINDOW];
  logic [CNT_W-1:0]    vote_cnt;
  logic                vote_c;
  logic [SAMPLE_W-1:0] med_x_c;
  logic [SAMPLE_W-1:0] med_y_c;
  logic [SAMPLE_W-1:0] med_x;
  logic [SAMPLE_W-1:0] med_y;
  logic                vote_pass;

  // Mapping
  logic [SAMPLE_W-1:0]   sel_m;
  logic [SAMPLE_W-1:0]   sel_lo;
  logic [SAMPLE_W-1:0]   sel_hi;
  logic [SIZE_W-1:0]     sel_size;
  logic signed [10:0]    span_c;
  logic signed [11:0]    offs_c;
  logic [10:0]           span_neg;
  logic [11:0]           offs_neg;
  logic [9:0]            abs_s_c;
  logic [10:0]           abs_d_c;
  logic [9:0]            abs_s;
  logic [10:0]           abs_d;
  logic                  neg_q;
  logic                  zero_span;
  logic [10:0]           divisor;
  logic [10:0]           rem;
  logic [DIV_W-1:0]      quo;
  logic [12:0]           trial;
  logic [POS_W-1:0]      pos_c;
  logic signed [POS_W-1:0] held_x;
  logic signed [POS_W-1:0] held_y;
  logic [REC_W-1:0]      rec_count;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh       <= RST_THRESH;
      edge_left    <= RST_LEFT;
      edge_right   <= RST_RIGHT;
      edge_top     <= RST_TOP;
      edge_bottom  <= RST_BOTTOM;
      plate_width  <= RST_WIDTH;
      plate_height <= RST_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESH: thresh       <= cfg_data[SAMPLE_W-1:0];
        REG_LEFT:   edge_left    <= cfg_data[SAMPLE_W-1:0];
        REG_RIGHT:  edge_right   <= cfg_data[SAMPLE_W-1:0];
        REG_TOP:    edge_top     <= cfg_data[SAMPLE_W-1:0];
        REG_BOTTOM: edge_bottom  <= cfg_data[SAMPLE_W-1:0];
        REG_WIDTH:  plate_width  <= cfg_data;
        REG_HEIGHT: plate_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Store accepted word into its window slot
  always_ff @(posedge clk) begin
    if (cmd.load_window) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (slot == SLOT_W'(i)) begin
          x_win[i] <= sample_x;
          y_win[i] <= sample_y;
          marks[i] <= (pressure > thresh);
        end
      end
    end
  end

  // Advance slot, wrap after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (cmd.load_window) begin
      slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    end
  end

  // Rank each entry (ties broken by slot order), pick the middle one; count marks for the vote
  always_comb begin
    med_x_c = '0;
    med_y_c = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank_x[i] = '0;
      rank_y[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (x_win[j] < x_win[i] || (x_win[j] == x_win[i] && j < i)) begin
          rank_x[i] = rank_x[i] + 1'b1;
        end
        if (y_win[j] < y_win[i] || (y_win[j] == y_win[i] && j < i)) begin
          rank_y[i] = rank_y[i] + 1'b1;
        end
      end
      if (rank_x[i] == CNT_W'(MID)) begin
        med_x_c = med_x_c | x_win[i];
      end
      if (rank_y[i] == CNT_W'(MID)) begin
        med_y_c = med_y_c | y_win[i];
      end
    end
    vote_cnt = CNT_W'($countones(marks));
    vote_c   = ({1'b0, vote_cnt, 1'b0} > (CNT_W + 2)'(WINDOW));
  end

  // Hold vote and medians for the mapping steps
  always_ff @(posedge clk) begin
    if (rst) begin
      vote_pass <= 1'b0;
    end else if (cmd.eval) begin
      vote_pass <= vote_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      med_x <= med_x_c;
      med_y <= med_y_c;
    end
  end

  // Axis select: physical X from median Y, physical Y from median X
  always_comb begin
    sel_m    = cmd.axis ? med_x        : med_y;
    sel_lo   = cmd.axis ? edge_bottom  : edge_left;
    sel_hi   = cmd.axis ? edge_top     : edge_right;
    sel_size = cmd.axis ? plate_height : plate_width;
    span_c   = $signed({1'b0, sel_hi}) - $signed({1'b0, sel_lo});
    offs_c   = $signed({2'b00, sel_lo}) + $signed({2'b00, sel_hi})
             - $signed({1'b0, sel_m, 1'b0});
    span_neg = -span_c;
    offs_neg = -offs_c;
    abs_s_c  = span_c[10] ? span_neg[9:0] : span_c[9:0];
    abs_d_c  = offs_c[11] ? offs_neg[10:0] : offs_c[10:0];
  end

  // Divide by 2*|span|; rounding folds into dividend + |span|
  assign divisor = {abs_s, 1'b0};
  assign trial   = {1'b0, rem, quo[DIV_W-1]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      abs_s     <= abs_s_c;
      abs_d     <= abs_d_c;
      neg_q     <= span_c[10] ^ offs_c[11];
      zero_span <= (span_c == '0);
    end
    if (cmd.mul) begin
      quo <= DIV_W'(sel_size) * DIV_W'(abs_d) + DIV_W'(abs_s);
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!trial[12]) begin
        rem <= trial[10:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[9:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  // Apply sign and saturate; a zero span gives zero
  always_comb begin
    if (zero_span) begin
      pos_c = '0;
    end else if (neg_q) begin
      pos_c = (quo > DIV_W'(32768)) ? POS_MIN : -quo[POS_W-1:0];
    end else begin
      pos_c = (quo > DIV_W'(32767)) ? POS_MAX : quo[POS_W-1:0];
    end
  end

  // Keep last position per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
    end else if (cmd.finish) begin
      if (cmd.axis) begin
        held_y <= $signed(pos_c);
      end else begin
        held_x <= $signed(pos_c);
      end
    end
  end

  // Output register and record counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rec_count <= '0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
      rec_count <= rec_count + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      record_number  <= rec_count;
      pos_x_centi    <= held_x;
      pos_y_centi    <= held_y;
      position_valid <= vote_pass;
    end
  end

  assign stat.last_slot = (slot == LAST_SLOT);
  assign stat.vote_pass = vote_pass;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: hw/rtl/touch_position_median_filter.sv
// Touch position median filter top level: controller plus datapath.
// Output: one record after every WINDOW accepted words. A failed vote skips mapping and goes
// from vote to record load; a passed vote first runs the 28-step serial divider once
// per axis (setup, multiply, 28 steps, finish each). The load waits for a free output register.
// Throughput: one word per cycle while a window fills; none is taken again until the record loads.
// Reset: synchronous; clears configuration to defaults, window fill, held position, counter.
`timescale 1ns / 1ps
`default_nettype none

module touch_position_median_filter #(
  parameter int unsigned WINDOW = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tpmf_pkg::SAMPLE_W-1:0]       sample_x,
  input  wire logic [tpmf_pkg::SAMPLE_W-1:0]       sample_y,
  input  wire logic [tpmf_pkg::SAMPLE_W-1:0]       pressure,
  input  wire logic                                cfg_write,
  input  wire logic [tpmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tpmf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tpmf_pkg::REC_W-1:0]               record_number,
  output logic signed [tpmf_pkg::POS_W-1:0]        pos_x_centi,
  output logic signed [tpmf_pkg::POS_W-1:0]        pos_y_centi,
  output logic                                     position_valid
);
  import tpmf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tpmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tpmf_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .sample_x       (sample_x),
    .sample_y       (sample_y),
    .pressure       (pressure),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .record_number  (record_number),
    .pos_x_centi    (pos_x_centi),
    .pos_y_centi    (pos_y_centi),
    .position_valid (position_valid)
  );

  // At most one datapath operation per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_window, cmd.eval, cmd.setup, cmd.mul, cmd.div_step,
              cmd.finish, cmd.emit}))
    else $error("overlapping datapath commands");

  // A record is loaded only into a free output register and then shows
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free ##1 out_valid)
    else $error("record loaded into busy output register");

  // New output word appears only after a load
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid without record load");

endmodule

`default_nettype wire

// File: tb/tb_touch_position_median_filter.sv
// Self-checking bench for the touch position median filter against a vote/median/map model.
`timescale 1ns / 1ps
module tb_touch_position_median_filter;
  import tpmf_pkg::*;

  localparam int WINDOW       = 3;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 40;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t p;
  } reading_t;

  typedef struct packed {
    logic [REC_W-1:0]        number;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    valid;
  } record_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sample_t               sample_x = '0;
  sample_t               sample_y = '0;
  sample_t               pressure = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [REC_W-1:0]      record_number;
  logic signed [POS_W-1:0] pos_x_centi;
  logic signed [POS_W-1:0] pos_y_centi;
  logic                  position_valid;

  touch_position_median_filter #(.WINDOW(WINDOW)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_x       (sample_x),
    .sample_y       (sample_y),
    .pressure       (pressure),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .record_number  (record_number),
    .pos_x_centi    (pos_x_centi),
    .pos_y_centi    (pos_y_centi),
    .position_valid (position_valid)
  );

  // Predictor copy of calibration and filter state
  sample_t             thr_cfg    = RST_THRESH;
  sample_t             left_cfg   = RST_LEFT;
  sample_t             right_cfg  = RST_RIGHT;
  sample_t             top_cfg    = RST_TOP;
  sample_t             bottom_cfg = RST_BOTTOM;
  logic [SIZE_W-1:0]   width_cfg  = RST_WIDTH;
  logic [SIZE_W-1:0]   height_cfg = RST_HEIGHT;
  sample_t             win_x[WINDOW];
  sample_t             win_y[WINDOW];
  logic                win_touch[WINDOW];
  int                  win_fill = 0;
  logic signed [POS_W-1:0] held_x = '0;
  logic signed [POS_W-1:0] held_y = '0;
  logic [REC_W-1:0]    record_count = '0;

  reading_t pending_readings[$];
  record_t  expected_records[$];

  int       mismatch_count = 0;
  int       records_seen = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       ready_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  reading_t next_word;
  record_t  want_rec;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int median3(int a, int b, int c);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  // Map a raw median onto the plate, round half away from zero, saturate
  function automatic logic signed [POS_W-1:0] scale_axis(int m, int lo, int hi, int size);
    longint num, den, q;
    bit     neg;
    num = longint'(size) * longint'(lo + hi - 2 * m);
    den = 2 * longint'(hi - lo);
    neg = 1'b0;
    if (den == 0) return '0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0) begin
      neg = 1'b1;
      num = -num;
    end
    q = (2 * num + den) / (2 * den);
    if (neg) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[POS_W-1:0];
  endfunction

  // Add one accepted word to the window; on a full window queue the record
  function automatic void track_reading(reading_t r);
    int      votes;
    record_t rec;
    win_x[win_fill]     = r.x;
    win_y[win_fill]     = r.y;
    win_touch[win_fill] = (r.p > thr_cfg);
    win_fill++;
    if (win_fill < WINDOW) return;
    win_fill = 0;
    votes = 0;
    for (int i = 0; i < WINDOW; i++) votes += int'(win_touch[i]);
    rec.valid = (votes * 2 > WINDOW);
    if (rec.valid) begin
      // axes swap: median Y drives physical X
      held_x = scale_axis(median3(int'(win_y[0]), int'(win_y[1]), int'(win_y[2])),
                          int'(left_cfg), int'(right_cfg), int'(width_cfg));
      held_y = scale_axis(median3(int'(win_x[0]), int'(win_x[1]), int'(win_x[2])),
                          int'(bottom_cfg), int'(top_cfg), int'(height_cfg));
    end
    rec.number = record_count;
    rec.pos_x  = held_x;
    rec.pos_y  = held_y;
    expected_records.push_back(rec);
    record_count++;
  endfunction

  // Drive input words in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) track_reading(reading_t'({sample_x, sample_y, pressure}));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_readings.size() != 0) begin
          next_word = pending_readings.pop_front();
          sample_x  <= next_word.x;
          sample_y  <= next_word.y;
          pressure  <= next_word.p;
          in_valid  <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && records_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_left <= $urandom_range(0, 9);
    end else begin
      out_ready  <= 1'b1;
      ready_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 30);
    end
  end

  // Check each accepted record against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      records_seen <= records_seen + 1;
      if (expected_records.size() == 0) begin
        note_mismatch($sformatf("unexpected record %0d", record_number));
      end else begin
        want_rec = expected_records.pop_front();
        if (record_number !== want_rec.number)
          note_mismatch($sformatf("record_number %0d, want %0d", record_number, want_rec.number));
        if (pos_x_centi !== want_rec.pos_x)
          note_mismatch($sformatf("record %0d pos_x_centi %0d, want %0d",
                                  want_rec.number, pos_x_centi, want_rec.pos_x));
        if (pos_y_centi !== want_rec.pos_y)
          note_mismatch($sformatf("record %0d pos_y_centi %0d, want %0d",
                                  want_rec.number, pos_y_centi, want_rec.pos_y));
        if (position_valid !== want_rec.valid)
          note_mismatch($sformatf("record %0d position_valid %0b, want %0b",
                                  want_rec.number, position_valid, want_rec.valid));
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("touch_position_median_filter: mismatch");
      $finish;
    end
  end

  task automatic add_reading(int x, int y, int p);
    reading_t r;
    r.x = sample_t'(x);
    r.y = sample_t'(y);
    r.p = sample_t'(p);
    pending_readings.push_back(r);
  endtask

  function automatic sample_t near(int c);
    int v;
    v = c + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return sample_t'(v);
  endfunction

  // Pressure on the chosen side of the threshold, often right at the boundary
  function automatic sample_t pick_pressure(bit touch);
    int t;
    t = int'(thr_cfg);
    if (touch && t < 1023)
      return sample_t'(($urandom_range(0, 3) == 0) ? t + 1 : $urandom_range(t + 1, 1023));
    return sample_t'(($urandom_range(0, 3) == 0) ? t : $urandom_range(0, t));
  endfunction

  // Queue whole windows: mostly a passing vote around one point, some noise
  task automatic queue_random_windows(int count);
    int       kind, cx, cy;
    bit [2:0] touch_mask;
    reading_t r;
    repeat (count) begin
      kind       = int'($urandom_range(0, 9));
      touch_mask = 3'($urandom_range(0, 7));
      if (kind < 6) touch_mask = touch_mask | 3'(3'b011 << $urandom_range(0, 1));
      cx = int'($urandom_range(0, 1023));
      cy = int'($urandom_range(0, 1023));
      if (kind < 2) begin
        // aim at the calibration edges
        cx = $urandom_range(0, 1) ? int'(bottom_cfg) : int'(top_cfg);
        cy = $urandom_range(0, 1) ? int'(left_cfg) : int'(right_cfg);
      end
      for (int i = 0; i < WINDOW; i++) begin
        if (kind == 9) begin
          r.x = sample_t'($urandom_range(0, 1023));
          r.y = sample_t'($urandom_range(0, 1023));
          r.p = sample_t'($urandom_range(0, 1023));
        end else if (kind >= 7) begin
          r.x = sample_t'($urandom_range(0, 1023));
          r.y = sample_t'($urandom_range(0, 1023));
          r.p = pick_pressure(touch_mask[i]);
        end else begin
          r.x = near(cx);
          r.y = near(cy);
          r.p = pick_pressure(touch_mask[i]);
        end
        pending_readings.push_back(r);
      end
    end
  endtask

  // Wait until every word is taken and every record is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (pending_readings.size() != 0 || in_valid || expected_records.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_THRESH: thr_cfg    = value[SAMPLE_W-1:0];
      REG_LEFT:   left_cfg   = value[SAMPLE_W-1:0];
      REG_RIGHT:  right_cfg  = value[SAMPLE_W-1:0];
      REG_TOP:    top_cfg    = value[SAMPLE_W-1:0];
      REG_BOTTOM: bottom_cfg = value[SAMPLE_W-1:0];
      REG_WIDTH:  width_cfg  = value[SIZE_W-1:0];
      REG_HEIGHT: height_cfg = value[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int unsigned thr, int unsigned left, int unsigned right,
                                int unsigned top, int unsigned bottom,
                                int unsigned width, int unsigned height);
    write_reg(REG_THRESH, thr);
    write_reg(REG_LEFT, left);
    write_reg(REG_RIGHT, right);
    write_reg(REG_TOP, top);
    write_reg(REG_BOTTOM, bottom);
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_random_settings();
    apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(500, 30000),
                   $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(500, 30000));
  endtask

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      win_x[i]     = '0;
      win_y[i]     = '0;
      win_touch[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed windows at reset calibration
    // failed vote before any fresh position: held zero
    add_reading(0, 0, 0);
    add_reading(1023, 1023, 3);
    add_reading(512, 512, 0);
    // pressure just over the threshold passes the vote
    add_reading(1023, 0, 4);
    add_reading(0, 1023, 1023);
    add_reading(500, 512, 3);
    // single contact: hold the last position
    add_reading(100, 900, 4);
    add_reading(200, 800, 3);
    add_reading(300, 700, 0);
    // extremes of both axes
    add_reading(0, 0, 1023);
    add_reading(0, 0, 1023);
    add_reading(0, 0, 1023);
    add_reading(1023, 1023, 1023);
    add_reading(1023, 1023, 1023);
    add_reading(1023, 1023, 1023);
    // repeated values in the median
    add_reading(5, 900, 10);
    add_reading(900, 900, 0);
    add_reading(5, 1, 10);
    // medians right on the calibration edges
    add_reading(936, 957, 512);
    add_reading(92, 54, 513);
    add_reading(936, 54, 700);
    add_reading(341, 682, 0);
    add_reading(682, 341, 1023);
    add_reading(1, 2, 2);
    queue_random_windows(50);
    drain();

    apply_random_settings();
    queue_random_windows(44);
    drain();

    // zero X span, reversed full-range Y span, largest plate
    apply_settings(0, 700, 700, 0, 1023, 65535, 65535);
    queue_random_windows(44);
    drain();

    // contact impossible, zero Y span, empty plate width
    apply_settings(1023, 0, 1023, 400, 400, 0, 1);
    queue_random_windows(12);
    drain();

    // one-count spans: drive both axes into saturation
    apply_settings(512, 500, 501, 501, 500, 65535, 65535);
    queue_random_windows(44);
    drain();

    apply_random_settings();
    queue_random_windows(44);
    drain();

    apply_random_settings();
    queue_random_windows(44);
    drain();

    apply_settings($urandom_range(0, 1023), RST_LEFT, RST_RIGHT, RST_TOP, RST_BOTTOM,
                   RST_WIDTH, RST_HEIGHT);
    queue_random_windows(30);
    drain();

    if (mismatch_count == 0) begin
      $display("touch_position_median_filter: match");
    end else begin
      $display("touch_position_median_filter: mismatch");
    end
    $finish;
  end

endmodule

// File: touch_position_median_filter.f
hw/rtl/tpmf_pkg.sv
hw/rtl/tpmf_ctrl.sv
hw/rtl/tpmf_dp.sv
hw/rtl/touch_position_median_filter.sv
tb/tb_touch_position_median_filter.sv
